@@ rtl/cht_pkg.sv @@
package cht_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] StartByte = 8'h2A;
  localparam logic [7:0] TermBang  = 8'h21;
  localparam logic [7:0] TermNul   = 8'h00;

  localparam int unsigned JobQueueDepth = 4;

  // One finished command, or a bad start byte, handed from the front to the back.
  typedef struct packed {
    logic        err;
    logic [15:0] crc;
  } job_t;

  function automatic logic is_term(input logic [7:0] b);
    return (b == TermBang) || (b == TermNul);
  endfunction

  // CRC-16, MSB first, one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Upper-case ASCII hex digit of the CRC, digit 0 is the most significant.
  function automatic logic [7:0] crc_hex(input logic [15:0] crc, input logic [1:0] idx);
    logic [3:0] nib;
    unique case (idx)
      2'd0:    nib = crc[15:12];
      2'd1:    nib = crc[11:8];
      2'd2:    nib = crc[7:4];
      default: nib = crc[3:0];
    endcase
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end else begin
      return 8'h37 + {4'h0, nib};
    end
  endfunction

endpackage

@@ rtl/cht_front.sv @@
module cht_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       byte_in_i,
  input  logic             full_i,
  output logic             push_o,
  output cht_pkg::job_t    push_job_o
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhBody    = 2'd1,
    PhDiscard = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic        accept;
  logic        term;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign term       = cht_pkg::is_term(byte_in_i);

  always_comb begin
    phase_d    = phase_q;
    crc_d      = crc_q;
    push_o     = 1'b0;
    push_job_o = '{err: 1'b0, crc: crc_q};
    if (accept) begin
      unique case (phase_q)
        PhBody: begin
          if (term) begin
            push_o  = 1'b1;
            phase_d = PhIdle;
            crc_d   = cht_pkg::CrcInit;
          end else begin
            crc_d = cht_pkg::crc_byte(crc_q, byte_in_i);
          end
        end
        PhDiscard: begin
          if (term) begin
            phase_d = PhIdle;
          end
        end
        default: begin
          crc_d = cht_pkg::CrcInit;
          if (byte_in_i == cht_pkg::StartByte) begin
            phase_d = PhBody;
          end else begin
            push_o         = 1'b1;
            push_job_o.err = 1'b1;
            phase_d        = term ? PhIdle : PhDiscard;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      crc_q   <= cht_pkg::CrcInit;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
    end
  end

`ifndef SYNTHESIS
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !push_job_o.err) |=> (crc_q == cht_pkg::CrcInit))
    else $error("CRC not restarted after a finished command");
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDiscard) |-> !push_o)
    else $error("Result pushed while discarding");
`endif

endmodule

@@ rtl/cht_fifo.sv @@
module cht_fifo #(
  parameter int unsigned Depth = cht_pkg::JobQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cht_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cht_pkg::job_t head_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cht_pkg::job_t         mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Job queue count out of range");
`endif

endmodule

@@ rtl/cht_back.sv @@
module cht_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cht_pkg::job_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    hex_char_o,
  output logic          error_o,
  output logic          last_o
);

  logic          busy_q, busy_d;
  cht_pkg::job_t job_q, job_d;
  logic [1:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    hex_q;
  logic          err_q, last_q;

  logic          slot_free;
  logic          emit;
  logic [7:0]    emit_hex;
  logic          emit_err, emit_last;

  assign slot_free = !out_valid_q || !out_stall_i;

  // The job in hand goes first; otherwise the queue head is taken straight
  // into the output register.
  always_comb begin
    busy_d    = busy_q;
    job_d     = job_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_hex  = 8'h00;
    emit_err  = 1'b0;
    emit_last = 1'b0;
    if (slot_free) begin
      if (busy_q) begin
        emit      = 1'b1;
        emit_hex  = cht_pkg::crc_hex(job_q.crc, idx_q);
        emit_last = (idx_q == 2'd3);
        idx_d     = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          busy_d = 1'b0;
        end
      end else if (!empty_i) begin
        pop_o = 1'b1;
        emit  = 1'b1;
        if (head_i.err) begin
          emit_err  = 1'b1;
          emit_last = 1'b1;
        end else begin
          emit_hex = cht_pkg::crc_hex(head_i.crc, 2'd0);
          busy_d   = 1'b1;
          job_d    = head_i;
          idx_d    = 2'd1;
        end
      end
    end
    out_valid_d = slot_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (slot_free && emit) begin
      hex_q  <= emit_hex;
      err_q  <= emit_err;
      last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hex_char_o  = hex_q;
  assign error_o     = err_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_busy_crc_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (!job_q.err && idx_q != 2'd0))
    else $error("Digit sequencer holds an error job or a spent digit");
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (last_o && hex_char_o == 8'h00))
    else $error("Error result is not a single zero result");
`endif

endmodule

@@ rtl/command_crc16_hex_tagger_top.sv @@
// Command CRC-16 tagger: command bytes in, ASCII hex CRC digits or error results out.
// A terminator's job is written into the job queue; the back end moves the queue head
// into the output register as its first hex digit (or the error result), and the other
// three digits follow. Throughput: one byte per cycle in, one result per cycle out while
// out_stall_i is low; the input stalls only while the four-entry job queue is full.
// Reset (rst_ni low, asynchronous): idle, CRC at 0xFFFF, queue empty, no output valid.
module command_crc16_hex_tagger_top #(
  parameter int unsigned JobQueueDepth = cht_pkg::JobQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] hex_char_o,
  output logic       error_o,
  output logic       last_o
);

  // The front end parses each request byte, tracks the command phase and runs
  // the CRC over each accepted byte. A finished command (or a bad start byte)
  // becomes one job in the queue.
  logic          push;
  cht_pkg::job_t push_job;
  logic          full;

  // The back end turns each job into one error result or four hex digits.
  logic          pop;
  cht_pkg::job_t head;
  logic          empty;

  cht_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .full_i     (full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  // The queue lets the front keep taking bytes while the back is still
  // spelling out an earlier CRC or waiting on a stalled output.
  cht_fifo #(
    .Depth (JobQueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  cht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hex_char_o  (hex_char_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule
